FILE: rtl/hsv_pkg.sv
// Shared constants, types and sector codes for the HSV to RGB converter.
package hsv_pkg;

    // Fixed-point format of saturation and value
    localparam int FRAC_BITS  = 14;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int UNIT_W     = FRAC_BITS + 1;

    // Port widths
    localparam int IN_W       = 16;
    localparam int CHAN_W     = 8;

    // Hue wrap: bias makes any 16-bit signed hue positive, a multiple of 360
    localparam int HUE_WRAP   = 360;
    localparam int SECTOR_DEG = 60;
    localparam int HUE_BIAS   = ((2 ** (IN_W - 1) + HUE_WRAP - 1) / HUE_WRAP) * HUE_WRAP;
    localparam int U_W        = IN_W + 1;
    localparam int HUE_DIV_SH = 24;
    localparam int HUE_DIV_M  = (2 ** HUE_DIV_SH + HUE_WRAP - 1) / HUE_WRAP;
    localparam int HUE_M_W    = 16;
    localparam int HUE_P_W    = U_W + HUE_M_W;
    localparam int HUE_Q_W    = 8;
    localparam int REM_W      = 9;
    localparam int K_W        = 6;

    // Component datapath widths
    localparam int INNER_MAX  = SECTOR_DEG * ONE;
    localparam int INNER_W    = FRAC_BITS + K_W;
    localparam int SK_W       = UNIT_W + K_W;
    localparam int PROD_W     = UNIT_W + INNER_W;
    localparam int SCALE_W    = PROD_W + CHAN_W;
    localparam int Y_W        = SCALE_W - 2 * FRAC_BITS;

    // Divide by 60 via reciprocal, exact for y < 23831 (y stays below 15361)
    localparam int DIV60_SH   = 20;
    localparam int DIV60_M    = (2 ** DIV60_SH + SECTOR_DEG - 1) / SECTOR_DEG;
    localparam int DIV60_M_W  = 15;
    localparam int Z_W        = Y_W + DIV60_M_W;

    // Component lanes
    localparam int LANES  = 4;
    localparam int LANE_V = 0;
    localparam int LANE_P = 1;
    localparam int LANE_Q = 2;
    localparam int LANE_T = 3;

    // Hue sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic    valid;
        sector_t sector;
    } tag_t;

endpackage

FILE: rtl/hsv_hue.sv
// Hue wrap, sector split and saturation/value clamp: three pipeline stages.
module hsv_hue
    import hsv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IN_W-1:0]     hue_deg,
    input  logic [IN_W-1:0]     saturation,
    input  logic [IN_W-1:0]     brightness,
    output tag_t                tag,
    output logic [K_W-1:0]      rem,
    output logic [UNIT_W-1:0]   sat,
    output logic [UNIT_W-1:0]   val
);

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic [IN_W-1:0] x);
        logic [UNIT_W-1:0] res;
        if (x[IN_W-1]) begin
            res = '0;
        end
        else if (x > IN_W'(ONE)) begin
            res = UNIT_W'(ONE);
        end
        else begin
            res = x[UNIT_W-1:0];
        end
        return res;
    endfunction

    // stage 1: bias hue positive, reciprocal multiply for /360
    logic [U_W-1:0]     u_next;
    logic [HUE_P_W-1:0] qprod_next;
    logic               valid1_reg;
    logic [U_W-1:0]     u1_reg;
    logic [HUE_Q_W-1:0] q1_reg;
    logic [UNIT_W-1:0]  s1_reg;
    logic [UNIT_W-1:0]  v1_reg;

    assign u_next     = U_W'(signed'(hue_deg)) + U_W'(HUE_BIAS);
    assign qprod_next = HUE_P_W'(u_next) * HUE_P_W'(HUE_DIV_M);

    // stage 2: remainder mod 360
    logic [U_W-1:0]     qmul;
    logic [REM_W-1:0]   rem2_next;
    logic               valid2_reg;
    logic [REM_W-1:0]   rem2_reg;
    logic [UNIT_W-1:0]  s2_reg;
    logic [UNIT_W-1:0]  v2_reg;

    assign qmul      = U_W'(q1_reg) * U_W'(HUE_WRAP);
    assign rem2_next = REM_W'(u1_reg - qmul);

    // stage 3: sector and offset inside sector
    sector_t            sector_next;
    logic [REM_W-1:0]   base;
    logic [K_W-1:0]     r3_next;
    tag_t               tag3_reg;
    logic [K_W-1:0]     r3_reg;
    logic [UNIT_W-1:0]  s3_reg;
    logic [UNIT_W-1:0]  v3_reg;

    always_comb
    begin
        if (rem2_reg >= REM_W'(5 * SECTOR_DEG)) begin
            sector_next = SEC_M_R;
            base        = REM_W'(5 * SECTOR_DEG);
        end
        else if (rem2_reg >= REM_W'(4 * SECTOR_DEG)) begin
            sector_next = SEC_B_M;
            base        = REM_W'(4 * SECTOR_DEG);
        end
        else if (rem2_reg >= REM_W'(3 * SECTOR_DEG)) begin
            sector_next = SEC_C_B;
            base        = REM_W'(3 * SECTOR_DEG);
        end
        else if (rem2_reg >= REM_W'(2 * SECTOR_DEG)) begin
            sector_next = SEC_G_C;
            base        = REM_W'(2 * SECTOR_DEG);
        end
        else if (rem2_reg >= REM_W'(SECTOR_DEG)) begin
            sector_next = SEC_Y_G;
            base        = REM_W'(SECTOR_DEG);
        end
        else begin
            sector_next = SEC_R_Y;
            base        = '0;
        end
    end

    assign r3_next = K_W'(rem2_reg - base);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            tag3_reg   <= '0;
        end
        else begin
            valid1_reg      <= start;
            valid2_reg      <= valid1_reg;
            tag3_reg.valid  <= valid2_reg;
            tag3_reg.sector <= sector_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u1_reg   <= u_next;
        q1_reg   <= qprod_next[HUE_DIV_SH +: HUE_Q_W];
        s1_reg   <= clamp_unit(saturation);
        v1_reg   <= clamp_unit(brightness);
        rem2_reg <= rem2_next;
        s2_reg   <= s1_reg;
        v2_reg   <= v1_reg;
        r3_reg   <= r3_next;
        s3_reg   <= s2_reg;
        v3_reg   <= v2_reg;
    end

    assign tag = tag3_reg;
    assign rem = r3_reg;
    assign sat = s3_reg;
    assign val = v3_reg;

endmodule

FILE: rtl/hsv_comp.sv
// Four component lanes (v, p, q, t): five pipeline stages of exact fixed point.
module hsv_comp
    import hsv_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tag_t                            tag_in,
    input  logic [K_W-1:0]                  rem_in,
    input  logic [UNIT_W-1:0]               sat_in,
    input  logic [UNIT_W-1:0]               val_in,
    output tag_t                            tag_out,
    output logic [LANES-1:0][CHAN_W-1:0]    chan
);

    logic [K_W-1:0]     k      [LANES];
    logic [SK_W-1:0]    sk_reg [LANES];
    logic [INNER_W-1:0] inner_reg [LANES];
    logic [PROD_W-1:0]  prod_reg  [LANES];
    logic [SCALE_W-1:0] scaled    [LANES];
    logic [Y_W-1:0]     y_reg     [LANES];
    logic [Z_W-1:0]     z_reg     [LANES];
    logic [UNIT_W-1:0]  va_reg;
    logic [UNIT_W-1:0]  vb_reg;
    tag_t               tag_a_reg;
    tag_t               tag_b_reg;
    tag_t               tag_c_reg;
    tag_t               tag_d_reg;
    tag_t               tag_e_reg;

    // weight k per lane: inner = 60*ONE - s*k
    always_comb
    begin
        k[LANE_V] = '0;
        k[LANE_P] = K_W'(SECTOR_DEG);
        k[LANE_Q] = rem_in;
        k[LANE_T] = K_W'(SECTOR_DEG) - rem_in;
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++) begin
            scaled[i] = {SCALE_W'(prod_reg[i]) << CHAN_W} - SCALE_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
        end
        else begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
            tag_e_reg <= tag_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg <= val_in;
        vb_reg <= va_reg;
        for (int i = 0; i < LANES; i++) begin
            sk_reg[i]    <= SK_W'(sat_in) * SK_W'(k[i]);
            inner_reg[i] <= INNER_W'(INNER_MAX) - INNER_W'(sk_reg[i]);
            prod_reg[i]  <= PROD_W'(vb_reg) * PROD_W'(inner_reg[i]);
            // times 255, then drop 2*FRAC_BITS
            y_reg[i]     <= scaled[i][SCALE_W-1 -: Y_W];
            // divide by 60
            z_reg[i]     <= Z_W'(y_reg[i]) * Z_W'(DIV60_M);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++) begin
            chan[i] = z_reg[i][DIV60_SH +: CHAN_W];
        end
    end

    assign tag_out = tag_e_reg;

endmodule

FILE: rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: hue stages, component lanes, channel select.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+-------------------------------
//  input   | hue_deg, saturation, brightness (16b s)  | word taken when start && !busy
//  result  | red, green, blue (8b u)                  | done high for one cycle/word
//
// One word enters per clock; busy is always low. A word passes the hue
// wrap/sector split stages, the component lanes (k*s, inner term,
// v*inner multiply, x255 scale, divide by 60) and the channel select
// register. Reset (rst_n, async) clears only the valid and tag registers,
// not the datapath, so nothing is in flight afterwards. The receiver cannot stall;
// results stream out in input order with no back-pressure.
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IN_W-1:0]   hue_deg,
    input  logic [IN_W-1:0]   saturation,
    input  logic [IN_W-1:0]   brightness,
    output logic              done,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    tag_t                         hue_tag;
    logic [K_W-1:0]               hue_rem;
    logic [UNIT_W-1:0]            hue_sat;
    logic [UNIT_W-1:0]            hue_val;
    tag_t                         comp_tag;
    logic [LANES-1:0][CHAN_W-1:0] comp_chan;

    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic              done_reg;

    // fully pipelined, never holds off a word
    assign busy = 1'b0;

    hsv_hue u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness),
        .tag        (hue_tag),
        .rem        (hue_rem),
        .sat        (hue_sat),
        .val        (hue_val)
    );

    hsv_comp u_comp (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (hue_tag),
        .rem_in  (hue_rem),
        .sat_in  (hue_sat),
        .val_in  (hue_val),
        .tag_out (comp_tag),
        .chan    (comp_chan)
    );

    // six-way placement of v, p, q, t by sector
    always_comb
    begin
        unique case (comp_tag.sector)
            SEC_Y_G:
            begin
                red_next   = comp_chan[LANE_Q];
                green_next = comp_chan[LANE_V];
                blue_next  = comp_chan[LANE_P];
            end
            SEC_G_C:
            begin
                red_next   = comp_chan[LANE_P];
                green_next = comp_chan[LANE_V];
                blue_next  = comp_chan[LANE_T];
            end
            SEC_C_B:
            begin
                red_next   = comp_chan[LANE_P];
                green_next = comp_chan[LANE_Q];
                blue_next  = comp_chan[LANE_V];
            end
            SEC_B_M:
            begin
                red_next   = comp_chan[LANE_T];
                green_next = comp_chan[LANE_P];
                blue_next  = comp_chan[LANE_V];
            end
            SEC_M_R:
            begin
                red_next   = comp_chan[LANE_V];
                green_next = comp_chan[LANE_P];
                blue_next  = comp_chan[LANE_Q];
            end
            SEC_R_Y:
            begin
                red_next   = comp_chan[LANE_V];
                green_next = comp_chan[LANE_T];
                blue_next  = comp_chan[LANE_P];
            end
            default:
            begin
                red_next   = comp_chan[LANE_V];
                green_next = comp_chan[LANE_T];
                blue_next  = comp_chan[LANE_P];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= comp_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the HSV to RGB converter: directed color table, then random words.
module tb;
    import hsv_pkg::*;

    localparam int RANDOM_WORDS = 650;
    localparam int TAIL_CYCLES  = 12;       // longer than the pipeline depth
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } color_t;

    // One row of the directed table; known marks rows whose color is typed in.
    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] bri;
        logic            known;
        color_t          color;
    } color_row_t;

    localparam logic [IN_W-1:0] FULL = IN_W'(ONE);

    // Primaries and secondaries at full saturation/value, clamping, grays,
    // black, hue wrap on both sides, then mid values left to the predictor.
    color_row_t color_table [24] = '{
        '{16'sd0,      FULL,        FULL,        1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'sd60,     FULL,        FULL,        1'b1, '{8'd255, 8'd255, 8'd0}},
        '{16'sd120,    FULL,        FULL,        1'b1, '{8'd0,   8'd255, 8'd0}},
        '{16'sd180,    FULL,        FULL,        1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'sd240,    FULL,        FULL,        1'b1, '{8'd0,   8'd0,   8'd255}},
        '{16'sd300,    FULL,        FULL,        1'b1, '{8'd255, 8'd0,   8'd255}},
        '{16'sd360,    FULL,        FULL,        1'b1, '{8'd255, 8'd0,   8'd0}},
        '{-16'sd120,   FULL,        FULL,        1'b1, '{8'd0,   8'd0,   8'd255}},
        '{16'sd77,     16'sd0,      FULL,        1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'sd200,    FULL,        16'sd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'sd45,     16'sd9000,   16'h8000,    1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'sd10,     16'h8000,    16'sd32767,  1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'sd120,    16'sd32767,  16'sd32767,  1'b1, '{8'd0,   8'd255, 8'd0}},
        '{16'sd61,     -16'sd1,     16'sd16385,  1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'h8000,    FULL,        FULL,        1'b0, '0},
        '{16'sd32767,  16'sd8192,   16'sd12000,  1'b0, '0},
        '{16'sd359,    16'sd16383,  16'sd16383,  1'b0, '0},
        '{-16'sd1,     16'sd12345,  16'sd9876,   1'b0, '0},
        '{16'sd30,     16'sd8192,   FULL,        1'b0, '0},
        '{16'sd59,     16'sd1,      16'sd1,      1'b0, '0},
        '{16'sd150,    16'sd8000,   16'sd8000,   1'b0, '0},
        '{16'sd270,    16'sd4000,   16'sd14000,  1'b0, '0},
        '{16'sd330,    FULL,        16'sd10000,  1'b0, '0},
        '{-16'sd1000,  16'sd3000,   16'sd16000,  1'b0, '0}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [IN_W-1:0]   hue_deg;
    logic [IN_W-1:0]   saturation;
    logic [IN_W-1:0]   brightness;
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    // Typed-in color travels with the word it belongs to
    logic              color_known;
    color_t            known_color;

    color_t            pending_colors [$];
    int                err_count = 0;
    int                cycles = 0;

    hsv_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Color predictor
    // ---------------------------------------------------------------

    // Negative means zero, above 1.0 means 1.0
    function automatic int clamp_unit(logic [IN_W-1:0] raw);
        int x;
        x = int'($signed(raw));
        if (x < 0)
            return 0;
        if (x > ONE)
            return ONE;
        return x;
    endfunction

    // floor(v * (1 - s*k/60) * 255), all in exact integers
    function automatic logic [CHAN_W-1:0] shade(int v, int s, int k);
        longint inner;
        longint num;
        inner = longint'(SECTOR_DEG) * ONE - longint'(s) * k;
        num   = longint'(v) * inner * 255;
        return CHAN_W'(num / (longint'(SECTOR_DEG) * ONE * ONE));
    endfunction

    function automatic color_t rgb_of_hsv(logic [IN_W-1:0] hue_raw,
                                          logic [IN_W-1:0] sat_raw,
                                          logic [IN_W-1:0] bri_raw);
        int                hue;
        int                s;
        int                v;
        int                rem;
        sector_t           sec;
        logic [CHAN_W-1:0] cv;
        logic [CHAN_W-1:0] cp;
        logic [CHAN_W-1:0] cq;
        logic [CHAN_W-1:0] ct;
        color_t            c;
        hue = int'($signed(hue_raw)) % HUE_WRAP;   // truncates toward zero
        if (hue < 0)
            hue += HUE_WRAP;
        s   = clamp_unit(sat_raw);
        v   = clamp_unit(bri_raw);
        sec = sector_t'(hue / SECTOR_DEG);
        rem = hue % SECTOR_DEG;
        cv  = shade(v, s, 0);
        cp  = shade(v, s, SECTOR_DEG);
        cq  = shade(v, s, rem);
        ct  = shade(v, s, SECTOR_DEG - rem);
        case (sec)
            SEC_Y_G: c = '{cq, cv, cp};
            SEC_G_C: c = '{cp, cv, ct};
            SEC_C_B: c = '{cp, cq, cv};
            SEC_B_M: c = '{ct, cp, cv};
            SEC_M_R: c = '{cv, cp, cq};
            default: c = '{cv, ct, cp};
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: both sides sampled at the edge that accepts them
    // ---------------------------------------------------------------

    task automatic check_channel(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        color_t want;
        if (rst_n)
        begin
            // word taken at this edge -> queue its color
            if (start && busy === 1'b0)
                pending_colors.push_back(color_known ? known_color
                                         : rgb_of_hsv(hue_deg, saturation, brightness));
            if ($isunknown(done))
            begin
                $error("done is unknown");
                err_count++;
            end
            else if (done)
            begin
                if (pending_colors.size() == 0)
                begin
                    $error("result word with nothing expected: %0d %0d %0d", red, green, blue);
                    err_count++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    check_channel("red",   want.r, red);
                    check_channel("green", want.g, green);
                    check_channel("blue",  want.b, blue);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Present one word and hold it until the edge that takes it
    task automatic send_word(logic [IN_W-1:0] h, logic [IN_W-1:0] s, logic [IN_W-1:0] v,
                             logic known, color_t c);
        start       <= 1'b1;
        hue_deg     <= h;
        saturation  <= s;
        brightness  <= v;
        color_known <= known;
        known_color <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Drop start and idle; fields carry junk that must be ignored
    task automatic idle_for(int n);
        start       <= 1'b0;
        hue_deg     <= IN_W'($urandom);
        saturation  <= IN_W'($urandom);
        brightness  <= IN_W'($urandom);
        color_known <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Mostly in-range fractions, some corners, some full 16-bit noise
    function automatic logic [IN_W-1:0] pick_unit();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return IN_W'($urandom_range(0, ONE));
        if (sel < 8)
            case ($urandom_range(0, 3))
                0: return '0;
                1: return IN_W'(ONE);
                2: return IN_W'(ONE - 1);
                default: return IN_W'(ONE + 1);
            endcase
        return IN_W'($urandom);
    endfunction

    // Mostly 0..359, some sector borders, some any 16-bit hue
    function automatic logic [IN_W-1:0] pick_hue();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return IN_W'($urandom_range(0, HUE_WRAP - 1));
        if (sel < 8)
            return IN_W'(SECTOR_DEG * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
        return IN_W'($urandom);
    endfunction

    initial
    begin
        int sent;
        int burst;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        hue_deg     <= '0;
        saturation  <= '0;
        brightness  <= '0;
        color_known <= 1'b0;
        known_color <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with the odd gap between rows
        foreach (color_table[i])
        begin
            send_word(color_table[i].hue, color_table[i].sat, color_table[i].bri,
                      color_table[i].known, color_table[i].color);
            if ($urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 10));
        end

        // Random words in bursts; long bursts give stretches with no idling
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RANDOM_WORDS; i++)
            begin
                send_word(pick_hue(), pick_unit(), pick_unit(), 1'b0, '0);
                sent++;
            end
            idle_for($urandom_range(1, 12));
        end

        // Drain, then let any stray result show up
        start <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            $error("%0d result words never arrived", pending_colors.size());
            err_count++;
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
